>>> src/vtesc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vtesc_pkg
// shared types and constants of the terminal escape parser
// ----------------------------------------------------------------------------
package vtesc_pkg;

  localparam int MAX_PARAMS_DEF = 16;
  localparam int LAST_LINE_DEF  = 23;

  localparam logic [7:0] ESC_CODE  = 8'h1b;
  localparam logic [7:0] BS_CODE   = 8'h08;
  localparam logic [17:0] PARAM_DEF = 18'h3ffff;   // -1
  localparam logic [17:0] PARAM_QM  = 18'h3fffe;   // -2
  localparam logic [17:0] PARAM_SAT = 18'd65535;

  typedef enum logic [2:0] {
    KIND_GLYPH = 3'd0,
    KIND_CTRL  = 3'd1,
    KIND_ESC   = 3'd2,
    KIND_CSI   = 3'd3,
    KIND_HASH  = 3'd4
  } kind_t;

  typedef enum logic [2:0] {
    ST_NORMAL = 3'd0,
    ST_ESC    = 3'd1,
    ST_CSI    = 3'd2,
    ST_HASH   = 3'd3,
    ST_G0     = 3'd4,
    ST_G1     = 3'd5
  } esc_state_t;

  // back part sequencing
  typedef enum logic [1:0] {
    B_IDLE, B_SGR, B_FIN
  } bst_t;

  // work for the back part
  typedef enum logic [3:0] {
    OP_NONE,      // no result
    OP_EMIT,      // emit kind/code with no side effect
    OP_EMIT2,     // escape echo, two glyphs
    OP_SO,
    OP_SI,
    OP_KP_SET,
    OP_KP_CLR,
    OP_RIS,
    OP_CSI_ENTER,
    OP_DIGIT,
    OP_QMARK,
    OP_SEMI,
    OP_CSI_FINAL,
    OP_CSI_ABORT,
    OP_GSET
  } op_t;

  typedef struct packed {
    op_t         op;
    kind_t       kind;
    logic [7:0]  code;
    logic        g1;
    logic        gval;
  } cmd_t;

  function automatic logic is_csi_final(input logic [7:0] c);
    case (c)
      "A", "B", "C", "D", "H", "f", "J", "K", "L", "M", "P", "c", "g",
      "h", "i", "l", "m", "n", "q", "r": is_csi_final = 1'b1;
      default: is_csi_final = 1'b0;
    endcase
  endfunction

endpackage
`default_nettype wire

>>> src/vtesc_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vtesc_front
// escape level tracking and byte classification into commands
// ----------------------------------------------------------------------------
module vtesc_front (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  wire logic [7:0]      in_byte,
  output logic                 cmd_valid,
  input  wire logic            cmd_ready,
  output vtesc_pkg::cmd_t      cmd
);
  import vtesc_pkg::*;

  esc_state_t st_r, st_nxt;
  cmd_t       c;
  logic       take;

  assign in_ready  = cmd_ready;
  assign cmd_valid = in_valid;
  assign take      = in_valid && cmd_ready;
  assign cmd       = c;

  // next escape level
  always_comb begin
    st_nxt = st_r;
    if (!(in_byte == BS_CODE && st_r != ST_NORMAL)) begin
      case (st_r)
        ST_NORMAL: if (in_byte == ESC_CODE) st_nxt = ST_ESC;
        ST_ESC: begin
          case (in_byte)
            "[": st_nxt = ST_CSI;
            "#": st_nxt = ST_HASH;
            "(": st_nxt = ST_G0;
            ")": st_nxt = ST_G1;
            default: st_nxt = ST_NORMAL;
          endcase
        end
        ST_CSI: begin
          if (!((in_byte >= "0" && in_byte <= "9") || in_byte == "?" || in_byte == ";"))
            st_nxt = ST_NORMAL;
        end
        default: st_nxt = ST_NORMAL;
      endcase
    end
  end

  // command for the back part
  always_comb begin
    c = '{op: OP_NONE, kind: KIND_GLYPH, code: in_byte, g1: 1'b0, gval: 1'b0};
    if (in_byte == BS_CODE && st_r != ST_NORMAL) begin
      c.op = OP_EMIT; c.kind = KIND_CTRL;
    end else begin
      case (st_r)
        ST_NORMAL: begin
          if (in_byte >= 8'd32) c.op = OP_EMIT;
          else if (in_byte == 8'h07 || (in_byte >= 8'h08 && in_byte <= 8'h0d)) begin
            c.op = OP_EMIT; c.kind = KIND_CTRL;
          end else if (in_byte == 8'h0e) begin
            c.op = OP_SO; c.kind = KIND_CTRL;
          end else if (in_byte == 8'h0f) begin
            c.op = OP_SI; c.kind = KIND_CTRL;
          end
        end
        ST_ESC: begin
          c.kind = KIND_ESC;
          case (in_byte)
            "[": c.op = OP_CSI_ENTER;
            "#", "(", ")": c.op = OP_NONE;
            ">": c.op = OP_KP_CLR;
            "=": c.op = OP_KP_SET;
            "c": c.op = OP_RIS;
            "7", "8", "D", "E", "H", "M", "Z": c.op = OP_EMIT;
            default: begin c.op = OP_EMIT2; c.kind = KIND_GLYPH; end
          endcase
        end
        ST_CSI: begin
          c.kind = KIND_CSI;
          if (in_byte >= "0" && in_byte <= "9") c.op = OP_DIGIT;
          else if (in_byte == "?") c.op = OP_QMARK;
          else if (in_byte == ";") c.op = OP_SEMI;
          else c.op = is_csi_final(in_byte) ? OP_CSI_FINAL : OP_CSI_ABORT;
        end
        ST_HASH: begin
          c.kind = KIND_HASH;
          if (in_byte == "8") c.op = OP_EMIT;
        end
        ST_G0, ST_G1: begin
          c.g1 = (st_r == ST_G1);
          c.gval = (in_byte == "0" || in_byte == "2");
          if (in_byte == "A" || in_byte == "B" || in_byte == "1" || in_byte == "0" ||
              in_byte == "2") c.op = OP_GSET;
        end
        default: c.op = OP_NONE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) st_r <= ST_NORMAL;
    else if (take) st_r <= st_nxt;
  end

endmodule
`default_nettype wire

>>> src/vtesc_fifo.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vtesc_fifo
// two-entry command queue between front and back
// ----------------------------------------------------------------------------
module vtesc_fifo (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            wr_valid,
  output logic                 wr_ready,
  input  vtesc_pkg::cmd_t      wr_data,
  output logic                 rd_valid,
  input  wire logic            rd_ready,
  output vtesc_pkg::cmd_t      rd_data
);
  import vtesc_pkg::*;

  cmd_t       mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  logic       wr, rd;

  assign wr_ready = (cnt_r != 2'd2);
  assign rd_valid = (cnt_r != 2'd0);
  assign rd_data  = mem_r[rp_r];
  assign wr = wr_valid && wr_ready;
  assign rd = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (wr) mem_r[wp_r] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0; rp_r <= 1'b0; cnt_r <= 2'd0;
    end else begin
      if (wr) wp_r <= ~wp_r;
      if (rd) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, wr} - {1'b0, rd};
    end
  end

endmodule
`default_nettype wire

>>> src/vtesc_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vtesc_back
// parameter store, mode registers and result generation
// ----------------------------------------------------------------------------
module vtesc_back #(
  parameter int MAX_PARAMS = vtesc_pkg::MAX_PARAMS_DEF,
  parameter int LAST_LINE  = vtesc_pkg::LAST_LINE_DEF
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            cmd_valid,
  output logic                 cmd_ready,
  input  vtesc_pkg::cmd_t      cmd,
  output logic                 out_valid,
  input  wire logic            out_ready,
  output logic [71:0]          out_data,
  output logic [2:0]           out_kind,
  output logic                 out_last
);
  import vtesc_pkg::*;

  localparam int IW = (MAX_PARAMS > 1) ? $clog2(MAX_PARAMS) : 1;
  localparam logic [IW-1:0] IMAX = IW'(MAX_PARAMS - 1);
  localparam logic [4:0] LL  = 5'(LAST_LINE);
  localparam logic [4:0] LL1 = 5'(LAST_LINE - 1);

  logic [17:0]   prm_r [MAX_PARAMS];
  logic [IW-1:0] idx_r;
  logic [7:0]    rend_r;
  logic          g0_r, g1_r, so_r, kp_r;
  logic [1:0]    pm_r;
  logic [4:0]    top_r, bot_r;

  bst_t          bs_r, bs_nxt;
  cmd_t          cur_r;
  logic [IW-1:0] walk_r;
  logic          two_r;

  // result register
  logic          ov_r;
  logic          olast_r;
  kind_t         kind_r;
  logic [7:0]    code_r;
  logic [16:0]   p0_r, p1_r;
  logic [4:0]    cnt_r;
  logic          priv_r;

  logic          take;
  logic          res_free;
  logic          res_op;

  assign res_free  = !ov_r || out_ready;
  assign cmd_ready = (bs_r == B_IDLE) && res_free && !two_r;
  assign take      = cmd_valid && cmd_ready;
  assign out_valid = ov_r;
  assign out_last  = olast_r;
  assign out_kind  = kind_r;
  // mode fields are live: nothing that changes them is taken while a result waits
  assign out_data  = {3'b000, bot_r, top_r, kp_r, pm_r, rend_r, priv_r, cnt_r,
                      p1_r, p0_r, code_r};

  always_comb begin
    case (cmd.op)
      OP_EMIT, OP_EMIT2, OP_SO, OP_SI, OP_KP_SET, OP_KP_CLR, OP_RIS: res_op = 1'b1;
      default: res_op = 1'b0;
    endcase
  end

  // digit accumulate, one multiply by ten
  logic [17:0] dbase;
  logic [21:0] dsum;
  logic [17:0] dval;
  always_comb begin
    dbase = prm_r[idx_r][17] ? 18'd0 : prm_r[idx_r];
    dsum  = 22'(dbase) * 22'd10 + 22'(cmd.code - 8'd48);
    dval  = (dsum > 22'(PARAM_SAT)) ? PARAM_SAT : dsum[17:0];
  end

  // one sgr step
  logic [17:0] sp;
  logic [7:0]  sgr_nxt;
  always_comb begin
    sp = prm_r[walk_r];
    sgr_nxt = rend_r;
    if (sp[17] || sp == 18'd0) sgr_nxt = rend_r & 8'h80;
    else if (sp < 18'd8) sgr_nxt = rend_r | (8'd1 << sp[2:0] - 3'd1);
    else if (sp == 18'd22) sgr_nxt = rend_r & 8'hfe;
    else if (sp > 18'd22 && sp < 18'd28) sgr_nxt = rend_r & ~(8'd1 << 3'(sp - 18'd21));
  end

  // margins
  logic [4:0] mt, mb;
  always_comb begin
    if (prm_r[0][17] || prm_r[0] == 18'd0) mt = 5'd0;
    else if (prm_r[0] - 18'd1 > 18'(LL1)) mt = LL1;
    else mt = 5'(prm_r[0] - 18'd1);
    if (prm_r[1][17] || prm_r[1] <= 18'd1 || prm_r[1] - 18'd1 > 18'(LL)) mb = LL;
    else mb = 5'(prm_r[1] - 18'd1);
    if (mt >= mb) mt = mb - 5'd1;
  end

  logic prev_q;
  assign prev_q = (idx_r != '0) && (prm_r[idx_r - IW'(1)] == PARAM_QM);

  // any register still holding a question mark
  logic any_q;
  always_comb begin
    any_q = 1'b0;
    for (int i = 0; i < MAX_PARAMS; i++) if (prm_r[i] == PARAM_QM) any_q = 1'b1;
  end

  always_comb begin
    bs_nxt = bs_r;
    case (bs_r)
      B_IDLE: if (take && cmd.op == OP_CSI_FINAL)
                bs_nxt = (cmd.code == "m") ? B_SGR : B_FIN;
      B_SGR:  if (walk_r == idx_r) bs_nxt = B_FIN;
      B_FIN:  if (res_free) bs_nxt = B_IDLE;
      default: bs_nxt = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bs_r <= B_IDLE; ov_r <= 1'b0; olast_r <= 1'b0; two_r <= 1'b0;
      idx_r <= '0; rend_r <= '0; g0_r <= 1'b0; g1_r <= 1'b0; so_r <= 1'b0;
      kp_r <= 1'b0; pm_r <= '0; top_r <= '0; bot_r <= LL; walk_r <= '0;
      for (int i = 0; i < MAX_PARAMS; i++) prm_r[i] <= PARAM_DEF;
    end else begin
      bs_r <= bs_nxt;
      if (ov_r && out_ready) begin
        if (two_r) begin
          two_r <= 1'b0; olast_r <= 1'b1;
          code_r <= cur_r.code; kind_r <= KIND_GLYPH;
        end else if (!take) ov_r <= 1'b0;
      end
      if (take) begin
        cur_r   <= cmd;
        walk_r  <= '0;
        ov_r    <= res_op;
        olast_r <= (cmd.op != OP_EMIT2);
        two_r   <= (cmd.op == OP_EMIT2);
        code_r  <= (cmd.op == OP_EMIT2) ? ESC_CODE : cmd.code;
        kind_r  <= cmd.kind;
        p0_r <= '0; p1_r <= '0; cnt_r <= '0; priv_r <= 1'b0;
        case (cmd.op)
          OP_SO: begin rend_r[7] <= g1_r; so_r <= 1'b1; end
          OP_SI: begin rend_r[7] <= g0_r; so_r <= 1'b0; end
          OP_KP_SET: kp_r <= 1'b1;
          OP_KP_CLR: kp_r <= 1'b0;
          OP_RIS: begin
            rend_r <= '0; g0_r <= 1'b0; g1_r <= 1'b0; so_r <= 1'b0; kp_r <= 1'b0;
            top_r <= '0; bot_r <= LL;
          end
          OP_CSI_ENTER: begin
            for (int i = 0; i < MAX_PARAMS; i++) prm_r[i] <= PARAM_DEF;
            idx_r <= '0;
          end
          OP_DIGIT: prm_r[idx_r] <= dval;
          OP_QMARK: begin
            prm_r[idx_r] <= PARAM_QM;
            if (idx_r != IMAX) idx_r <= idx_r + IW'(1);
          end
          OP_SEMI: if (idx_r != IMAX) idx_r <= idx_r + IW'(1);
          OP_CSI_FINAL: begin
            case (cmd.code)
              "L", "M", "P": if (prm_r[0][17] || prm_r[0] == 18'd0) prm_r[0] <= 18'd1;
              "i": begin
                if (prm_r[idx_r] == 18'd5) pm_r <= prev_q ? 2'd2 : 2'd1;
                else if (prm_r[idx_r] == 18'd4) pm_r <= 2'd0;
              end
              "r": begin top_r <= mt; bot_r <= mb; end
              default: ;
            endcase
          end
          OP_GSET: begin
            if (cmd.g1) g1_r <= cmd.gval; else g0_r <= cmd.gval;
            if (cmd.g1 ? so_r : !so_r) rend_r[7] <= cmd.gval;
          end
          default: ;
        endcase
      end
      if (bs_r == B_SGR) begin
        rend_r <= sgr_nxt;
        if (walk_r != idx_r) walk_r <= walk_r + IW'(1);
      end
      if (bs_r == B_FIN && res_free) begin
        ov_r <= 1'b1; olast_r <= 1'b1;
        code_r <= cur_r.code;
        kind_r <= KIND_CSI;
        p0_r   <= prm_r[0][16:0];
        p1_r   <= prm_r[1][16:0];
        cnt_r  <= 5'(idx_r);
        priv_r <= any_q;
      end
    end
  end

endmodule
`default_nettype wire

>>> src/vt100_escape_parser_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vt100_escape_parser_core
// vt100 / ansi escape sequence parser with decoupled classify and execute
// ----------------------------------------------------------------------------
// channel | dir | tdata                          | tuser / tlast
// in_     | in  | rx_byte                        | -
// out_    | out | item_code, first/second param, | tuser: item_kind
//         |     | count, private, attribute,...  | tlast: last_of_run
//
// a byte transfer is taken whenever the two-entry command queue has room
// a result passes the command queue and then the result register; a csi final also passes the finish state
// csi 'm' first walks every parameter up to param_count in the sgr state
// an unknown escape gives two glyph transfers, the second loaded once the first is taken
// reset: synchronous, rst_n low; parameters reset to default, margins full
// stalls on out_tready hold the result register and back-pressure the queue
// ----------------------------------------------------------------------------
module vt100_escape_parser_core #(
  parameter int MAX_PARAMS = vtesc_pkg::MAX_PARAMS_DEF,
  parameter int LAST_LINE  = vtesc_pkg::LAST_LINE_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,    // rx_byte
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // item_code[7:0] first_param[24:8] second_param[41:25] param_count[46:42]
  // private_mode[47] attribute[55:48] print_mode[57:56] keypad_app[58]
  // top_margin[63:59] bottom_margin[68:64] zeros[71:69]
  output logic [71:0]      out_tdata,
  output logic [2:0]       out_tuser,   // item_kind
  output logic             out_tlast    // last_of_run
);
  import vtesc_pkg::*;

  cmd_t       f_cmd, q_cmd;
  logic       f_valid, f_ready, q_valid, q_ready;

  // classifier: tracks the escape level, one byte per transfer
  vtesc_front u_front (
    .clk, .rst_n, .in_valid(in_tvalid), .in_ready(in_tready), .in_byte(in_tdata),
    .cmd_valid(f_valid), .cmd_ready(f_ready), .cmd(f_cmd)
  );

  // short queue so the classifier can run ahead of the executor
  vtesc_fifo u_fifo (
    .clk, .rst_n, .wr_valid(f_valid), .wr_ready(f_ready), .wr_data(f_cmd),
    .rd_valid(q_valid), .rd_ready(q_ready), .rd_data(q_cmd)
  );

  // executor: parameters, modes and the result register
  vtesc_back #(.MAX_PARAMS(MAX_PARAMS), .LAST_LINE(LAST_LINE)) u_back (
    .clk, .rst_n, .cmd_valid(q_valid), .cmd_ready(q_ready), .cmd(q_cmd),
    .out_valid(out_tvalid), .out_ready(out_tready), .out_data(out_tdata),
    .out_kind(out_tuser), .out_last(out_tlast)
  );

endmodule
`default_nettype wire

>>> dv/vt100_escape_parser_core_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vt100_escape_parser_core_checker
// watches the byte and result streams, runs a software copy of the escape
// parser on every accepted byte and compares each result transfer in order
// ----------------------------------------------------------------------------
module vt100_escape_parser_core_checker #(
  parameter int MAX_PARAMS = vtesc_pkg::MAX_PARAMS_DEF,
  parameter int LAST_LINE  = vtesc_pkg::LAST_LINE_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  input  wire logic        in_tready,
  input  wire logic [7:0]  in_tdata,
  input  wire logic        out_tvalid,
  input  wire logic        out_tready,
  input  wire logic [71:0] out_tdata,
  input  wire logic [2:0]  out_tuser,
  input  wire logic        out_tlast,
  output int               fail_count,
  output int               pending
);
  import vtesc_pkg::*;

  typedef struct packed {
    logic [2:0]  kind;
    logic        last;
    logic [71:0] data;
  } item_t;

  item_t parsed_q[$];

  esc_state_t  lvl;
  int          prm[MAX_PARAMS];
  int          pidx;
  logic [7:0]  rend;
  logic        g0, g1, so, kp;
  logic [1:0]  prn;
  int          rtop, rbot;

  assign pending = parsed_q.size();

  task automatic report(input string what, input logic [71:0] got, input logic [71:0] want);
    $display("mismatch %s: got %h want %h", what, got, want);
    fail_count++;
  endtask

  function automatic item_t mk(input kind_t k, input logic [7:0] code, input int p0 = 0,
                               input int p1 = 0, input int cnt = 0, input bit priv = 0);
    item_t it;
    it.kind = k;
    it.last = 1'b0;
    it.data = '0;
    it.data[7:0]   = code;
    it.data[24:8]  = p0[16:0];
    it.data[41:25] = p1[16:0];
    it.data[46:42] = cnt[4:0];
    it.data[47]    = priv;
    return it;
  endfunction

  function automatic void clr_params();
    for (int i = 0; i < MAX_PARAMS; i++) prm[i] = -1;
    pidx = 0;
  endfunction

  function automatic void screen_reset();
    rend = 0; g0 = 0; g1 = 0; so = 0; kp = 0; rtop = 0; rbot = LAST_LINE;
  endfunction

  function automatic void set_graph(input logic on);
    rend[7] = on;
  endfunction

  // run one byte through the copy and queue what it produces
  function automatic void parse_byte(input logic [7:0] c);
    item_t res[$];
    int idx, p, t, b;
    bit priv, known, g1sel, act, v;
    if (c == BS_CODE && lvl != ST_NORMAL) begin
      res.push_back(mk(KIND_CTRL, c));
    end else begin
      case (lvl)
        ST_NORMAL: begin
          if (c >= 32) res.push_back(mk(KIND_GLYPH, c));
          else if (c == ESC_CODE) lvl = ST_ESC;
          else if (c == 8'h07 || (c >= 8'h08 && c <= 8'h0d)) res.push_back(mk(KIND_CTRL, c));
          else if (c == 8'h0e) begin
            set_graph(g1); so = 1; res.push_back(mk(KIND_CTRL, c));
          end else if (c == 8'h0f) begin
            set_graph(g0); so = 0; res.push_back(mk(KIND_CTRL, c));
          end
        end
        ST_ESC: begin
          lvl = ST_NORMAL;
          case (c)
            "[": begin clr_params(); lvl = ST_CSI; end
            "#": lvl = ST_HASH;
            "(": lvl = ST_G0;
            ")": lvl = ST_G1;
            ">": begin kp = 0; res.push_back(mk(KIND_ESC, c)); end
            "=": begin kp = 1; res.push_back(mk(KIND_ESC, c)); end
            "c": begin screen_reset(); res.push_back(mk(KIND_ESC, c)); end
            "7", "8", "D", "E", "H", "M", "Z": res.push_back(mk(KIND_ESC, c));
            default: begin
              res.push_back(mk(KIND_GLYPH, ESC_CODE));
              res.push_back(mk(KIND_GLYPH, c));
            end
          endcase
        end
        ST_CSI: begin
          idx = (pidx > MAX_PARAMS - 1) ? MAX_PARAMS - 1 : pidx;
          if (c >= "0" && c <= "9") begin
            p = prm[idx] < 0 ? 0 : prm[idx];
            p = p * 10 + (c - "0");
            prm[idx] = p > 65535 ? 65535 : p;
          end else if (c == "?") begin
            prm[idx] = -2;
            if (idx < MAX_PARAMS - 1) pidx = idx + 1;
          end else if (c == ";") begin
            if (idx < MAX_PARAMS - 1) pidx = idx + 1;
          end else begin
            known = 1;
            lvl = ST_NORMAL;
            case (c)
              "L", "M", "P": if (prm[0] < 1) prm[0] = 1;
              "i": begin
                if (prm[idx] == 5) prn = (idx > 0 && prm[idx-1] == -2) ? 2'd2 : 2'd1;
                else if (prm[idx] == 4) prn = 2'd0;
              end
              "m": begin
                // sgr walks every register up to the current index
                for (int k = 0; k <= pidx && k < MAX_PARAMS; k++) begin
                  p = prm[k];
                  if (p < 1) rend = rend & 8'h80;
                  else if (p < 8) rend[p-1] = 1'b1;
                  else if (p == 22) rend[0] = 1'b0;
                  else if (p > 21 && p < 28) rend[p-21] = 1'b0;
                end
              end
              "r": begin
                t = prm[0] < 0 ? 0 : prm[0] - 1;
                b = prm[1] < 0 ? LAST_LINE : prm[1] - 1;
                if (t < 0) t = 0;
                if (t > LAST_LINE - 1) t = LAST_LINE - 1;
                if (b < 1 || b > LAST_LINE) b = LAST_LINE;
                if (t >= b) t = b - 1;
                rtop = t; rbot = b;
              end
              "A", "B", "C", "D", "H", "f", "J", "K", "c", "g", "h", "l", "n", "q": ;
              default: known = 0;
            endcase
            if (known) begin
              priv = 0;
              for (int k = 0; k < MAX_PARAMS; k++) if (prm[k] == -2) priv = 1;
              res.push_back(mk(KIND_CSI, c, prm[0], prm[1], idx, priv));
            end
          end
        end
        ST_HASH: begin
          lvl = ST_NORMAL;
          if (c == "8") res.push_back(mk(KIND_HASH, c));
        end
        default: begin
          g1sel = (lvl == ST_G1);
          act = g1sel ? so : ~so;
          lvl = ST_NORMAL;
          if (c == "A" || c == "B" || c == "1" || c == "0" || c == "2") begin
            v = (c == "0" || c == "2");
            if (g1sel) g1 = v; else g0 = v;
            if (act) set_graph(v);
          end
        end
      endcase
    end
    // screen fields reflect the state after this byte
    foreach (res[i]) begin
      res[i].data[55:48] = rend;
      res[i].data[57:56] = prn;
      res[i].data[58]    = kp;
      res[i].data[63:59] = rtop[4:0];
      res[i].data[68:64] = rbot[4:0];
      res[i].last = (i == res.size() - 1);
      parsed_q.push_back(res[i]);
    end
  endfunction

  always @(posedge clk) begin
    item_t exp_it;
    if (!rst_n) begin
      lvl = ST_NORMAL;
      clr_params();
      prn = 0;
      screen_reset();
      parsed_q.delete();
      fail_count = 0;
    end else begin
      if (in_tvalid && in_tready) parse_byte(in_tdata);
      if (out_tvalid && out_tready) begin
        if (parsed_q.size() == 0) begin
          report("unexpected result", out_tdata, '0);
        end else begin
          exp_it = parsed_q.pop_front();
          if (out_tuser !== exp_it.kind) report("item_kind", out_tuser, exp_it.kind);
          if (out_tlast !== exp_it.last) report("last_of_run", out_tlast, exp_it.last);
          if (out_tdata[7:0] !== exp_it.data[7:0])
            report("item_code", out_tdata[7:0], exp_it.data[7:0]);
          if (out_tdata[24:8] !== exp_it.data[24:8])
            report("first_param", out_tdata[24:8], exp_it.data[24:8]);
          if (out_tdata[41:25] !== exp_it.data[41:25])
            report("second_param", out_tdata[41:25], exp_it.data[41:25]);
          if (out_tdata[46:42] !== exp_it.data[46:42])
            report("param_count", out_tdata[46:42], exp_it.data[46:42]);
          if (out_tdata[47] !== exp_it.data[47])
            report("private_mode", out_tdata[47], exp_it.data[47]);
          if (out_tdata[55:48] !== exp_it.data[55:48])
            report("attribute", out_tdata[55:48], exp_it.data[55:48]);
          if (out_tdata[57:56] !== exp_it.data[57:56])
            report("print_mode", out_tdata[57:56], exp_it.data[57:56]);
          if (out_tdata[58] !== exp_it.data[58])
            report("keypad_app", out_tdata[58], exp_it.data[58]);
          if (out_tdata[63:59] !== exp_it.data[63:59])
            report("top_margin", out_tdata[63:59], exp_it.data[63:59]);
          if (out_tdata[68:64] !== exp_it.data[68:64])
            report("bottom_margin", out_tdata[68:64], exp_it.data[68:64]);
        end
      end
    end
  end

endmodule

>>> dv/vt100_escape_parser_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vt100_escape_parser_core_tb
// drives directed and random terminal byte streams into the escape parser
// with random idling on both streams; the checker predicts and compares
// ----------------------------------------------------------------------------
module vt100_escape_parser_core_tb;
  import vtesc_pkg::*;

  localparam int WATCHDOG = 20000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [71:0] out_tdata;
  logic [2:0]  out_tuser;
  logic        out_tlast;
  int          fail_count;
  int          pending;

  // idling control shared with the receiver process
  bit          no_idle = 0;
  bit          hold_off = 0;
  bit          held = 0;
  int          quiet = 0;
  int          sent = 0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  vt100_escape_parser_core dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser), .out_tlast(out_tlast)
  );

  vt100_escape_parser_core_checker chk (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser), .out_tlast(out_tlast),
    .fail_count(fail_count), .pending(pending)
  );

  // receiver: random stalls, plus one long hold-off set by the stimulus process
  always @(posedge clk) begin
    if (!rst_n) out_tready <= 1'b0;
    else if (hold_off) out_tready <= 1'b0;
    else out_tready <= no_idle ? 1'b1 : ($urandom_range(0, 99) >= 31);
  end

  // watchdog: cycles with no transfer on either stream, outside the hold-off
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || hold_off) quiet <= 0;
      else quiet <= quiet + 1;
      if (quiet >= WATCHDOG) begin
        $display("vt100_escape_parser_core_tb failed");
        $finish;
      end
    end
  end

  // one byte transfer, with random idling before it
  task automatic send_byte(input logic [7:0] b);
    while (!no_idle && $urandom_range(0, 99) < 31) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sent++;
  endtask

  task automatic send_str(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  function automatic string rand_num();
    case ($urandom_range(0, 5))
      0: return "";
      1: return $sformatf("%0d", $urandom_range(0, 9));
      2: return $sformatf("%0d", $urandom_range(0, 30));
      3: return $sformatf("%0d", $urandom_range(0, 99999));
      4: return "?";
      default: return $sformatf("%0d", $urandom_range(0, 65535));
    endcase
  endfunction

  // csi sequence with random parameters, an occasional backspace and a known or random final byte
  task automatic send_csi();
    string finals = "ABCDHfJKLMPcghilmnqr";
    string s;
    int np;
    s = {8'h1b, "["};
    np = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 20) : $urandom_range(0, 3);
    for (int i = 0; i < np; i++) begin
      s = {s, rand_num()};
      if ($urandom_range(0, 3) != 0) s = {s, ";"};
    end
    s = {s, rand_num()};
    if ($urandom_range(0, 19) == 0) s = {s, 8'h08};
    if ($urandom_range(0, 9) == 0) s = {s, byte'($urandom_range(0, 255))};
    else s = {s, finals[$urandom_range(0, finals.len() - 1)]};
    send_str(s);
  endtask

  task automatic send_esc();
    string escs = "78cDEHMZ=>#()xQ";
    string gsets = "AB102Z";
    case ($urandom_range(0, 4))
      0: send_str({8'h1b, escs[$urandom_range(0, escs.len() - 1)]});
      1: send_str({8'h1b, "#", ($urandom_range(0, 1) ? "8" : byte'($urandom_range(0, 255)))});
      2: send_str({8'h1b, ($urandom_range(0, 1) ? "(" : ")"),
                   gsets[$urandom_range(0, gsets.len() - 1)]});
      3: send_byte($urandom_range(0, 1) ? 8'h0e : 8'h0f);
      default: send_str({8'h1b, byte'($urandom_range(0, 255))});
    endcase
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: extremes, controls, each escape level and csi corner
    send_str({8'h00, 8'hff, " ", 8'h07, 8'h0d, 8'h1f, 8'h0e, 8'h0f});
    send_str({8'h1b, "(0", 8'h1b, ")2", 8'h0e, 8'h0f, 8'h1b, "(B"});
    send_str({8'h1b, "=", 8'h1b, ">", 8'h1b, "#8", 8'h1b, "#3", 8'h1b, "q"});
    send_str({8'h1b, "[?5i", 8'h1b, "[5i", 8'h1b, "[4i", 8'h1b, "[0L"});
    send_str({8'h1b, "[1;4;7;22;24;27;0m", 8'h1b, "[999999;99r", 8'h1b, "[5;3r"});
    send_str({8'h1b, "[1;2;3;4;5;6;7;8;9;10;11;12;13;14;15;16;17;18m"});
    send_str({8'h1b, "[3", 8'h08, "H", 8'h1b, "[2", 8'h0a, 8'h1b, "c"});

    // random traffic, with one stretch of no idling
    while (sent < 450) begin
      no_idle = (sent >= 200 && sent < 300);
      case ($urandom_range(0, 9))
        0, 1, 2, 3: send_csi();
        4, 5: send_esc();
        default: send_byte($urandom_range(0, 255));
      endcase
      // long receiver hold-off while bytes keep coming
      if (!held && sent >= 340) begin
        held = 1;
        fork
          begin
            hold_off = 1;
            repeat (200) @(posedge clk);
            hold_off = 0;
          end
        join_none
      end
    end
    in_tvalid <= 1'b0;
    no_idle = 0;

    while (pending != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (fail_count == 0) $display("vt100_escape_parser_core_tb passed");
    else $display("vt100_escape_parser_core_tb failed");
    $finish;
  end

endmodule

>>> files.f
src/vtesc_pkg.sv
src/vtesc_front.sv
src/vtesc_fifo.sv
src/vtesc_back.sv
src/vt100_escape_parser_core.sv
dv/vt100_escape_parser_core_checker.sv
dv/vt100_escape_parser_core_tb.sv
